/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. They compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define AST_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_SAME(lbl, clk_s, rst_s, ante, cons)
`define AST_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* rtl/core/pmfi_pkg.sv */
`default_nettype none

package pmfi_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS     = 2'd0,
    REG_FRICTION = 2'd1,
    REG_MAX_X    = 2'd2,
    REG_MAX_Y    = 2'd3
  } cfg_reg_t;

  // Reset values of the configuration registers (Q16.16).
  localparam logic [30:0] MASS_RST     = 31'd65536;
  localparam logic [30:0] FRICTION_RST = 31'd196608000;
  localparam logic [30:0] MAX_SPD_RST  = 31'd32768000;

  // Iteration counts of the shared divide and square root unit, minus one.
  localparam logic [5:0] DIV_FORCE_LAST = 6'd47;
  localparam logic [5:0] DIV_FULL_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST      = 6'd31;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_ACCX, S_DIVY, S_ACCY, S_MULAX, S_VELX, S_VELY,
    S_FRS, S_SQX, S_SQY, S_CMP, S_SQRT, S_SQEND, S_DXLD, S_DIVDX,
    S_APPX, S_DYLD, S_DIVDY, S_APPY, S_CLAMP, S_MPX, S_PX, S_PY, S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/point_mass_friction_integrator_top.sv */
// Point-mass integrator with Coulomb friction, 2D, Q16.16 fixed point.
// Input channel (in_valid/in_ready) carries one frame item: force, extra
// acceleration, time step and current position. Output channel
// (out_valid/out_ready) returns one item per frame: new position and the
// velocity after friction and clamping. The velocity is kept inside.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes mass,
// friction coefficient and the two axis speed limits; write it while idle.
// When friction stops the body, an item skips the square root and the
// friction divisions. The work is done by the shared one-bit-per-cycle
// divide and square root unit: two 48-step force divisions, a 32-step
// square root and two 64-step friction divisions. A single 32x32
// multiplier serves all products.
// The block takes one item at a time; in_ready is high only while idle.
// A finished item sits in the output register, so a new item is accepted
// while it waits; if the receiver still stalls when the next item is done,
// the sequencer holds until the output register frees up.
// Reset clears the velocity, loads the default registers and empties the
// output register.
`default_nettype none
`include "assert_macros.svh"

module point_mass_friction_integrator_top (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [31:0] force_x,
  input  wire signed [31:0] force_y,
  input  wire signed [31:0] extra_accel_x,
  input  wire signed [31:0] extra_accel_y,
  input  wire        [15:0] time_step,
  input  wire signed [31:0] pos_x,
  input  wire signed [31:0] pos_y,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] vel_out_x,
  output logic signed [31:0] vel_out_y,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [pmfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [30:0] cfg_data
);

  // Magnitude of a signed 32-bit value; the most negative value gives 2^31.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (!v[33] && (v[32:31] != 2'b00)) sat34 = 32'h7FFF_FFFF;
    else if (v[33] && (v[32:31] != 2'b11)) sat34 = 32'h8000_0000;
    else sat34 = v[31:0];
  endfunction

  // Saturate a 50-bit signed sum to 32 bits.
  function automatic logic [31:0] sat50(input logic [49:0] v);
    if (!v[49] && (v[48:31] != 18'd0)) sat50 = 32'h7FFF_FFFF;
    else if (v[49] && (v[48:31] != 18'h3FFFF)) sat50 = 32'h8000_0000;
    else sat50 = v[31:0];
  endfunction

  pmfi_pkg::state_t state, state_next;

  // Configuration registers.
  logic [30:0] mass, friction_coeff, max_speed_x, max_speed_y;

  // Frame operands and persistent velocity.
  logic [31:0] fy, ex, ey, px, py, acc_x, acc_y, vel_x, vel_y;
  logic        fx_neg;
  logic [15:0] dt;
  logic [30:0] fr;
  logic [63:0] sum;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Shared divide / square root unit.
  logic [63:0] num;
  logic [33:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        sqrt_mode;
  logic [35:0] trial_lhs, trial_rhs, trial_diff;
  logic        trial_ge;

  // Helper values for the update states.
  logic [31:0] p_hi;
  logic [49:0] q_signed;
  logic [33:0] step_sum;
  logic [31:0] vx_mag, vy_mag;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == pmfi_pkg::S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mass           <= pmfi_pkg::MASS_RST;
      friction_coeff <= pmfi_pkg::FRICTION_RST;
      max_speed_x    <= pmfi_pkg::MAX_SPD_RST;
      max_speed_y    <= pmfi_pkg::MAX_SPD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pmfi_pkg::cfg_reg_t'(cfg_index))
        pmfi_pkg::REG_MASS:     mass           <= cfg_data;
        pmfi_pkg::REG_FRICTION: friction_coeff <= cfg_data;
        pmfi_pkg::REG_MAX_X:    max_speed_x    <= cfg_data;
        pmfi_pkg::REG_MAX_Y:    max_speed_y    <= cfg_data;
      endcase
    end
  end

  assign vx_mag = mag32(vel_x);
  assign vy_mag = mag32(vel_y);
  assign p_hi   = prod[47:16];

  // Multiplier operand selection; the product is registered and read in the following state.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      pmfi_pkg::S_MULAX: begin mul_a = mag32(acc_x); mul_b = {16'd0, dt}; end
      pmfi_pkg::S_VELX:  begin mul_a = mag32(acc_y); mul_b = {16'd0, dt}; end
      pmfi_pkg::S_VELY:  begin mul_a = {1'b0, friction_coeff}; mul_b = {16'd0, dt}; end
      pmfi_pkg::S_FRS:   begin mul_a = vx_mag; mul_b = vx_mag; end
      pmfi_pkg::S_SQX:   begin mul_a = vy_mag; mul_b = vy_mag; end
      pmfi_pkg::S_SQY:   begin mul_a = {1'b0, fr}; mul_b = {1'b0, fr}; end
      pmfi_pkg::S_SQEND: begin mul_a = {1'b0, fr}; mul_b = vx_mag; end
      pmfi_pkg::S_APPX:  begin mul_a = {1'b0, fr}; mul_b = vy_mag; end
      pmfi_pkg::S_MPX:   begin mul_a = vx_mag; mul_b = {16'd0, dt}; end
      pmfi_pkg::S_PX:    begin mul_a = vy_mag; mul_b = {16'd0, dt}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // One restoring step: a quotient bit or a root bit per cycle.
  assign sqrt_mode = (state == pmfi_pkg::S_SQRT);
  always_comb begin
    if (sqrt_mode) begin
      trial_lhs = {rem, num[63:62]};
      trial_rhs = {2'b00, dsr, 2'b01};
    end else begin
      trial_lhs = {3'b000, rem[31:0], num[63]};
      trial_rhs = {4'b0000, dsr};
    end
    trial_diff = trial_lhs - trial_rhs;
    trial_ge   = (trial_lhs >= trial_rhs);
  end

  // Force quotient with sign, and the generic signed step sum.
  always_comb begin
    q_signed = fx_neg ? (50'd0 - {2'b00, num[47:0]}) : {2'b00, num[47:0]};
    step_sum = 34'd0;
    case (state)
      pmfi_pkg::S_VELX: step_sum = {{2{vel_x[31]}}, vel_x} +
        (acc_x[31] ? (34'd0 - {2'b00, p_hi}) : {2'b00, p_hi});
      pmfi_pkg::S_VELY: step_sum = {{2{vel_y[31]}}, vel_y} +
        (acc_y[31] ? (34'd0 - {2'b00, p_hi}) : {2'b00, p_hi});
      pmfi_pkg::S_PX: step_sum = {{2{px[31]}}, px} +
        (vel_x[31] ? (34'd0 - {2'b00, p_hi}) : {2'b00, p_hi});
      pmfi_pkg::S_PY: step_sum = {{2{py[31]}}, py} +
        (vel_y[31] ? (34'd0 - {2'b00, p_hi}) : {2'b00, p_hi});
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= pmfi_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pmfi_pkg::S_IDLE:  if (in_valid) state_next = pmfi_pkg::S_DIVX;
      pmfi_pkg::S_DIVX:  if (cnt == 6'd0) state_next = pmfi_pkg::S_ACCX;
      pmfi_pkg::S_ACCX:  state_next = pmfi_pkg::S_DIVY;
      pmfi_pkg::S_DIVY:  if (cnt == 6'd0) state_next = pmfi_pkg::S_ACCY;
      pmfi_pkg::S_ACCY:  state_next = pmfi_pkg::S_MULAX;
      pmfi_pkg::S_MULAX: state_next = pmfi_pkg::S_VELX;
      pmfi_pkg::S_VELX:  state_next = pmfi_pkg::S_VELY;
      pmfi_pkg::S_VELY:  state_next = pmfi_pkg::S_FRS;
      pmfi_pkg::S_FRS:   state_next = pmfi_pkg::S_SQX;
      pmfi_pkg::S_SQX:   state_next = pmfi_pkg::S_SQY;
      pmfi_pkg::S_SQY:   state_next = pmfi_pkg::S_CMP;
      pmfi_pkg::S_CMP:   state_next = (sum <= prod) ? pmfi_pkg::S_CLAMP : pmfi_pkg::S_SQRT;
      pmfi_pkg::S_SQRT:  if (cnt == 6'd0) state_next = pmfi_pkg::S_SQEND;
      pmfi_pkg::S_SQEND: state_next = pmfi_pkg::S_DXLD;
      pmfi_pkg::S_DXLD:  state_next = pmfi_pkg::S_DIVDX;
      pmfi_pkg::S_DIVDX: if (cnt == 6'd0) state_next = pmfi_pkg::S_APPX;
      pmfi_pkg::S_APPX:  state_next = pmfi_pkg::S_DYLD;
      pmfi_pkg::S_DYLD:  state_next = pmfi_pkg::S_DIVDY;
      pmfi_pkg::S_DIVDY: if (cnt == 6'd0) state_next = pmfi_pkg::S_APPY;
      pmfi_pkg::S_APPY:  state_next = pmfi_pkg::S_CLAMP;
      pmfi_pkg::S_CLAMP: state_next = pmfi_pkg::S_MPX;
      pmfi_pkg::S_MPX:   state_next = pmfi_pkg::S_PX;
      pmfi_pkg::S_PX:    state_next = pmfi_pkg::S_PY;
      pmfi_pkg::S_PY:    state_next = pmfi_pkg::S_DONE;
      pmfi_pkg::S_DONE:  if (!out_valid || out_ready) state_next = pmfi_pkg::S_IDLE;
      default:           state_next = pmfi_pkg::S_IDLE;
    endcase
  end

  // Velocity state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_x <= 32'd0;
      vel_y <= 32'd0;
    end else begin
      case (state)
        pmfi_pkg::S_VELX: vel_x <= sat34(step_sum);
        pmfi_pkg::S_VELY: vel_y <= sat34(step_sum);
        pmfi_pkg::S_CMP: begin
          if (sum <= prod) begin
            vel_x <= 32'd0;
            vel_y <= 32'd0;
          end
        end
        pmfi_pkg::S_APPX: vel_x <= vel_x[31] ? (vel_x + num[31:0]) : (vel_x - num[31:0]);
        pmfi_pkg::S_APPY: vel_y <= vel_y[31] ? (vel_y + num[31:0]) : (vel_y - num[31:0]);
        pmfi_pkg::S_CLAMP: begin
          if (vx_mag > {1'b0, max_speed_x})
            vel_x <= vel_x[31] ? (32'd0 - {1'b0, max_speed_x}) : {1'b0, max_speed_x};
          if (vy_mag > {1'b0, max_speed_y})
            vel_y <= vel_y[31] ? (32'd0 - {1'b0, max_speed_y}) : {1'b0, max_speed_y};
        end
        default: ;
      endcase
    end
  end

  // Datapath registers of the frame in flight.
  always_ff @(posedge clk) begin
    case (state)
      pmfi_pkg::S_IDLE: begin
        if (in_valid) begin
          fx_neg <= force_x[31];
          fy     <= force_y;
          ex     <= extra_accel_x;
          ey     <= extra_accel_y;
          dt     <= time_step;
          px     <= pos_x;
          py     <= pos_y;
          num    <= {mag32(force_x), 32'd0};
          rem    <= 34'd0;
          dsr    <= (mass == 31'd0) ? 32'd1 : {1'b0, mass};
          cnt    <= pmfi_pkg::DIV_FORCE_LAST;
        end
      end
      pmfi_pkg::S_DIVX, pmfi_pkg::S_DIVY, pmfi_pkg::S_DIVDX, pmfi_pkg::S_DIVDY: begin
        rem <= trial_ge ? {2'b00, trial_diff[31:0]} : {2'b00, trial_lhs[31:0]};
        num <= {num[62:0], trial_ge};
        cnt <= cnt - 6'd1;
      end
      pmfi_pkg::S_ACCX: begin
        acc_x  <= sat50(q_signed + {{18{ex[31]}}, ex});
        fx_neg <= fy[31];
        num    <= {mag32(fy), 32'd0};
        rem    <= 34'd0;
        cnt    <= pmfi_pkg::DIV_FORCE_LAST;
      end
      pmfi_pkg::S_ACCY: acc_y <= sat50(q_signed + {{18{ey[31]}}, ey});
      pmfi_pkg::S_FRS:  fr    <= prod[46:16];
      pmfi_pkg::S_SQX:  sum   <= prod;
      pmfi_pkg::S_SQY:  sum   <= sum + prod;
      pmfi_pkg::S_CMP: begin
        num <= sum;
        rem <= 34'd0;
        dsr <= 32'd0;
        cnt <= pmfi_pkg::SQRT_LAST;
      end
      pmfi_pkg::S_SQRT: begin
        rem <= trial_ge ? trial_diff[33:0] : trial_lhs[33:0];
        num <= {num[61:0], 2'b00};
        dsr <= {dsr[30:0], trial_ge};
        cnt <= cnt - 6'd1;
      end
      pmfi_pkg::S_DXLD, pmfi_pkg::S_DYLD: begin
        num <= prod;
        rem <= 34'd0;
        cnt <= pmfi_pkg::DIV_FULL_LAST;
      end
      pmfi_pkg::S_PX: px <= sat34(step_sum);
      pmfi_pkg::S_PY: py <= sat34(step_sum);
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pmfi_pkg::S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmfi_pkg::S_DONE && (!out_valid || out_ready)) begin
      new_pos_x <= px;
      new_pos_y <= py;
      vel_out_x <= vel_x;
      vel_out_y <= vel_y;
    end
  end

  `AST_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == pmfi_pkg::S_DIVX)
  `AST_NEXT(a_done_delivers, clk, rst, state == pmfi_pkg::S_DONE && (!out_valid || out_ready), out_valid && in_ready)
  `AST_NEXT(a_divider_counts, clk, rst, state == pmfi_pkg::S_SQRT && cnt != 6'd0, state == pmfi_pkg::S_SQRT)
  `AST_SAME(a_busy_not_ready, clk, rst, state != pmfi_pkg::S_IDLE, !in_ready)

endmodule

`default_nettype wire

/* bench/pmfi_checker.sv */
`timescale 1ns / 1ps

module pmfi_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire signed [31:0] force_x,
  input  wire signed [31:0] force_y,
  input  wire signed [31:0] extra_accel_x,
  input  wire signed [31:0] extra_accel_y,
  input  wire        [15:0] time_step,
  input  wire signed [31:0] pos_x,
  input  wire signed [31:0] pos_y,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [31:0] new_pos_x,
  input  wire signed [31:0] new_pos_y,
  input  wire signed [31:0] vel_out_x,
  input  wire signed [31:0] vel_out_y,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire [pmfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [30:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } frame_result_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  frame_result_t frames_due[$];
  longint body_mass, fric_coeff, limit_x, limit_y;
  longint body_vx, body_vy;

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Product with the Q0.16 time step, truncated toward zero.
  function automatic longint scale_dt(longint a, longint dt);
    longint p;
    p = (absval(a) * dt) >>> 16;
    return a < 0 ? -p : p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (absval(v) > lim) return v < 0 ? -lim : lim;
    return v;
  endfunction

  // Advances the kept velocity by one frame and forms the result item.
  function automatic frame_result_t integrate_frame(longint fx, longint fy, longint ex,
                                                    longint ey, longint dt, longint px,
                                                    longint py);
    frame_result_t r;
    longint m, ax, ay, vx, vy, fr, dx, dy;
    longint unsigned ux, uy, sum, spd;
    m = (body_mass != 0) ? body_mass : 1;
    ax = sat32((fx * 65536) / m + ex);
    ay = sat32((fy * 65536) / m + ey);
    vx = sat32(body_vx + scale_dt(ax, dt));
    vy = sat32(body_vy + scale_dt(ay, dt));
    fr = (fric_coeff * dt) >>> 16;
    if (vx != 0 || vy != 0) begin
      ux = absval(vx);
      uy = absval(vy);
      sum = ux * ux + uy * uy;
      if (sum <= longint'(fr) * fr) begin
        vx = 0;
        vy = 0;
      end else begin
        spd = int_sqrt(sum);
        dx = (longint'(fr) * ux) / spd;
        dy = (longint'(fr) * uy) / spd;
        vx = vx < 0 ? vx + dx : vx - dx;
        vy = vy < 0 ? vy + dy : vy - dy;
      end
    end
    vx = clamp_to(vx, limit_x);
    vy = clamp_to(vy, limit_y);
    if (vx != 0 || vy != 0) begin
      px = sat32(px + scale_dt(vx, dt));
      py = sat32(py + scale_dt(vy, dt));
    end
    body_vx = vx;
    body_vy = vy;
    r.px = px[31:0];
    r.py = py[31:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    return r;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst) begin
      body_mass = 65536;
      fric_coeff = 196608000;
      limit_x = 32768000;
      limit_y = 32768000;
      body_vx = 0;
      body_vy = 0;
      fail_count = 0;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pmfi_pkg::cfg_reg_t'(cfg_index))
          pmfi_pkg::REG_MASS:     body_mass = cfg_data;
          pmfi_pkg::REG_FRICTION: fric_coeff = cfg_data;
          pmfi_pkg::REG_MAX_X:    limit_x = cfg_data;
          pmfi_pkg::REG_MAX_Y:    limit_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        frames_due.push_back(integrate_frame(force_x, force_y, extra_accel_x, extra_accel_y,
                                             time_step, pos_x, pos_y));
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("result item with no frame pending");
          fail_count = fail_count + 1;
        end else begin
          exp_r = frames_due.pop_front();
          if (new_pos_x !== exp_r.px) begin
            $error("new_pos_x expected %0d got %0d", exp_r.px, new_pos_x);
            fail_count = fail_count + 1;
          end
          if (new_pos_y !== exp_r.py) begin
            $error("new_pos_y expected %0d got %0d", exp_r.py, new_pos_y);
            fail_count = fail_count + 1;
          end
          if (vel_out_x !== exp_r.vx) begin
            $error("vel_out_x expected %0d got %0d", exp_r.vx, vel_out_x);
            fail_count = fail_count + 1;
          end
          if (vel_out_y !== exp_r.vy) begin
            $error("vel_out_y expected %0d got %0d", exp_r.vy, vel_out_y);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending_count = frames_due.size();
  end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic signed [31:0] force_x = 0, force_y = 0, extra_accel_x = 0, extra_accel_y = 0;
  logic [15:0] time_step = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0;
  logic cfg_valid = 0;
  logic [pmfi_pkg::CFG_IDX_W-1:0] cfg_index = pmfi_pkg::REG_MASS;
  logic [30:0] cfg_data = 0;
  wire in_ready, out_valid, cfg_ready;
  wire signed [31:0] new_pos_x, new_pos_y, vel_out_x, vel_out_y;
  int fail_count, pending_count;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_recv = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  point_mass_friction_integrator_top DUT (.*);

  pmfi_checker u_checker (.*);

  // Receiver: random stall, or a long forced hold-off.
  always @(negedge clk) begin
    if (rst || hold_recv) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("point_mass_friction_integrator_top verification failed");
      $finish;
    end
  end

  // Valid stays high after acceptance until the next item or a drain replaces it.
  task automatic send_frame(logic [31:0] fx, logic [31:0] fy, logic [31:0] ex,
                            logic [31:0] ey, logic [15:0] dt, logic [31:0] px,
                            logic [31:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    force_x <= fx; force_y <= fy; extra_accel_x <= ex; extra_accel_y <= ey;
    time_step <= dt; pos_x <= px; pos_y <= py;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_frames();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(pmfi_pkg::cfg_reg_t idx, logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(65536 * 64);
      3: return -$urandom_range(65536 * 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_frame();
    logic [15:0] dt;
    case ($urandom_range(7))
      0: dt = 16'd0;
      1: dt = 16'hffff;
      default: dt = 16'($urandom_range(4000));
    endcase
    if ($urandom_range(3) == 0) dt = 16'($urandom);
    send_frame(pick_value(), pick_value(), pick_value(), pick_value(), dt,
               pick_value(), pick_value());
  endtask

  task automatic random_config();
    write_reg(pmfi_pkg::REG_MASS, ($urandom_range(3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(1 << 20)));
    write_reg(pmfi_pkg::REG_FRICTION, ($urandom_range(1) == 0) ? 31'($urandom_range(1 << 24))
                                                               : 31'($urandom));
    write_reg(pmfi_pkg::REG_MAX_X, 31'($urandom));
    write_reg(pmfi_pkg::REG_MAX_Y, 31'($urandom_range(1 << 26)));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;

    // Directed frames: field extremes, zero step, friction stop, clamps.
    send_frame(0, 0, 0, 0, 0, 0, 0);
    send_frame(32'h7fffffff, 32'h80000000, 0, 0, 16'hffff, 32'h7fffffff, 32'h80000000);
    send_frame(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff,
               32'h7fffffff, 32'h7fffffff);
    send_frame(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'hffff,
               32'h80000000, 32'h80000000);
    send_frame(65536, 0, 0, 0, 16'h0100, 100, -100);
    send_frame(32'h01000000, -32'h00800000, 0, 0, 0, 5, 6);
    drain_frames();
    write_reg(pmfi_pkg::REG_MASS, 0);
    write_reg(pmfi_pkg::REG_FRICTION, 0);
    write_reg(pmfi_pkg::REG_MAX_X, 31'h7fffffff);
    write_reg(pmfi_pkg::REG_MAX_Y, 0);
    send_frame(3, -3, 0, 0, 16'hffff, 0, 0);
    send_frame(32'h7fffffff, 32'h7fffffff, 0, 0, 16'hffff, 32'h7ff00000, 1);
    send_frame(0, 0, 1, -1, 1, 0, 0);
    drain_frames();
    write_reg(pmfi_pkg::REG_MASS, 31'h7fffffff);
    write_reg(pmfi_pkg::REG_FRICTION, 31'h7fffffff);
    write_reg(pmfi_pkg::REG_MAX_X, 0);
    write_reg(pmfi_pkg::REG_MAX_Y, 31'h7fffffff);
    send_frame(32'h7fffffff, 32'h80000000, 32'h00100000, -32'h00100000, 16'h8000, 1, 2);
    send_frame(-1, 1, 32'h7fffffff, 32'h80000000, 16'hffff, 0, 0);
    drain_frames();

    // Random phases: each has its own idle mix and register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      random_config();
      for (int i = 0; i < 100; i++) random_frame();
      drain_frames();
    end

    // Long receiver hold-off while frames keep coming, so the input stalls.
    send_idle_pct = 0;
    fork
      begin
        hold_recv = 1;
        repeat (2000) @(negedge clk);
        hold_recv = 0;
      end
      for (int i = 0; i < 6; i++) random_frame();
    join
    drain_frames();

    if (fail_count == 0)
      $display("point_mass_friction_integrator_top verification clean");
    else
      $display("point_mass_friction_integrator_top verification failed");
    $finish;
  end
endmodule
